FILE: design/b64enc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// b64enc_pkg
// Types, register codes and the alphabet lookup of the base64 stream encoder.
// ----------------------------------------------------------------------------
package b64enc_pkg;

    // configuration register indexes
    localparam logic [1:0] CFG_CHAR_62  = 2'd0;
    localparam logic [1:0] CFG_CHAR_63  = 2'd1;
    localparam logic [1:0] CFG_PAD_CHAR = 2'd2;

    localparam logic [7:0] CHAR_62_RST  = 8'd43;
    localparam logic [7:0] CHAR_63_RST  = 8'd47;
    localparam logic [7:0] PAD_CHAR_RST = 8'd61;

    // request kinds
    localparam logic REQ_DATA  = 1'b0;
    localparam logic REQ_FLUSH = 1'b1;

    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_DIGIT_0 = 8'h30;

    localparam logic [5:0] SEXT_62 = 6'h3E;

    // characters left in the output burst
    localparam logic [2:0] BURST_NONE  = 3'd0;
    localparam logic [2:0] BURST_ONE   = 3'd1;
    localparam logic [2:0] BURST_TWO   = 3'd2;
    localparam logic [2:0] BURST_THREE = 3'd3;
    localparam logic [2:0] BURST_FOUR  = 3'd4;

    // number of bytes held
    typedef enum logic [2:0] {
        PH_EMPTY = 3'b001,
        PH_ONE   = 3'b010,
        PH_TWO   = 3'b100
    } t_phase;

    function automatic logic [7:0] sextet_char(
        input logic [5:0] v,
        input logic [7:0] c62,
        input logic [7:0] c63
    );
        logic [7:0] v8;
        logic [7:0] ch;
        v8 = {2'b00, v};
        if (v < 6'd26) begin
            ch = CH_UPPER_A + v8;
        end else if (v < 6'd52) begin
            ch = CH_LOWER_A - 8'd26 + v8;
        end else if (v < 6'd62) begin
            ch = CH_DIGIT_0 - 8'd52 + v8;
        end else if (v == SEXT_62) begin
            ch = c62;
        end else begin
            ch = c63;
        end
        return ch;
    endfunction

endpackage
`default_nettype wire

FILE: design/b64enc_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// b64enc_in_if
// Request channel of the base64 stream encoder: data byte or end-of-stream.
// ----------------------------------------------------------------------------
interface b64enc_in_if;
    logic       valid;
    logic       ready;
    logic       req_type;
    logic [7:0] data_byte;

    modport source (output valid, output req_type, output data_byte, input ready);
    modport sink   (input valid, input req_type, input data_byte, output ready);
endinterface
`default_nettype wire

FILE: design/b64enc_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// b64enc_out_if
// Character channel of the base64 stream encoder.
// ----------------------------------------------------------------------------
interface b64enc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       last_of_run;

    modport source (output valid, output out_char, output last_of_run, input ready);
    modport sink   (input valid, input out_char, input last_of_run, output ready);
endinterface
`default_nettype wire

FILE: design/base64_stream_encoder.sv
`default_nettype none
// ----------------------------------------------------------------------------
// base64_stream_encoder
// Streaming base64 encoder, one byte per request, one character per result.
// ----------------------------------------------------------------------------
// i_in carries requests: req_type 0 is a data byte, 1 ends the stream and
// flushes one or two held bytes as two or three characters plus pads.
// o_out carries one character per result; last_of_run marks the final
// character caused by a request. The write port sets char_62, char_63 and
// pad_char (0 turns padding off); write it only while the encoder is idle.
// A request that holds its byte leaves the input free for the next one. A
// request that yields characters fills a four-slot burst register in the
// accept cycle; the characters then leave one per cycle while the receiver
// takes them, passing from the burst register through the output register.
// The single-character output channel sets the rate. The next request is
// taken in the cycle the last character of the burst moves to the output
// register, so the input stays busy while the output register waits on a
// stalled receiver. Reset empties the hold register and burst, drops
// o_out.valid and loads the default alphabet characters '+', '/' and '='.
// ----------------------------------------------------------------------------
module base64_stream_encoder (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_we,
    input  wire logic [1:0] i_cfg_idx,
    input  wire logic [7:0] i_cfg_data,
    b64enc_in_if.sink       i_in,
    b64enc_out_if.source    o_out
);

    logic [7:0]             r_c62, r_c63, r_pad;
    logic [15:0]            r_held, n_held;
    b64enc_pkg::t_phase     r_phase, n_phase;

    logic [23:0]            r_word, n_word;
    logic [3:0]             r_mask, n_mask;
    logic [2:0]             r_left, n_left;

    logic                   r_ovalid;
    logic [7:0]             r_ochar;
    logic                   r_olast;

    logic                   w_acc;
    logic                   w_out_load;
    logic                   w_emit;
    logic                   w_pad_on;
    logic                   b_load;
    logic [23:0]            b_word;
    logic [3:0]             b_mask;
    logic [2:0]             b_left;

    assign w_out_load = !r_ovalid || o_out.ready;
    assign w_emit     = w_out_load && (r_left != b64enc_pkg::BURST_NONE);
    assign i_in.ready = (r_left == b64enc_pkg::BURST_NONE)
                     || ((r_left == b64enc_pkg::BURST_ONE) && w_out_load);
    assign w_acc      = i_in.valid && i_in.ready;
    assign w_pad_on   = (r_pad != 8'h00);

    assign o_out.valid       = r_ovalid;
    assign o_out.out_char    = r_ochar;
    assign o_out.last_of_run = r_olast;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c62 <= b64enc_pkg::CHAR_62_RST;
            r_c63 <= b64enc_pkg::CHAR_63_RST;
            r_pad <= b64enc_pkg::PAD_CHAR_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                b64enc_pkg::CFG_CHAR_62:  r_c62 <= i_cfg_data;
                b64enc_pkg::CFG_CHAR_63:  r_c63 <= i_cfg_data;
                b64enc_pkg::CFG_PAD_CHAR: r_pad <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // request decode: hold the byte or build a burst of characters
    always_comb begin
        n_held = r_held;
        n_phase = r_phase;
        b_load = 1'b0;
        b_word = {r_held, 8'h00};
        b_mask = 4'b0000;
        b_left = b64enc_pkg::BURST_NONE;
        if (w_acc) begin
            if (i_in.req_type == b64enc_pkg::REQ_DATA) begin
                unique case (r_phase)
                    b64enc_pkg::PH_ONE: begin
                        n_held  = {r_held[15:8], i_in.data_byte};
                        n_phase = b64enc_pkg::PH_TWO;
                    end
                    b64enc_pkg::PH_TWO: begin
                        b_load  = 1'b1;
                        b_word  = {r_held, i_in.data_byte};
                        b_left  = b64enc_pkg::BURST_FOUR;
                        n_held  = 16'h0000;
                        n_phase = b64enc_pkg::PH_EMPTY;
                    end
                    default: begin
                        n_held  = {i_in.data_byte, 8'h00};
                        n_phase = b64enc_pkg::PH_ONE;
                    end
                endcase
            end else begin
                unique case (r_phase)
                    b64enc_pkg::PH_ONE: begin
                        b_load = 1'b1;
                        b_left = w_pad_on ? b64enc_pkg::BURST_FOUR : b64enc_pkg::BURST_TWO;
                        b_mask = w_pad_on ? 4'b0011 : 4'b0000;
                    end
                    b64enc_pkg::PH_TWO: begin
                        b_load = 1'b1;
                        b_left = w_pad_on ? b64enc_pkg::BURST_FOUR : b64enc_pkg::BURST_THREE;
                        b_mask = w_pad_on ? 4'b0001 : 4'b0000;
                    end
                    default: begin
                    end
                endcase
                n_held  = 16'h0000;
                n_phase = b64enc_pkg::PH_EMPTY;
            end
        end
    end

    // burst register: shifts one sextet out per emitted character
    always_comb begin
        n_word = r_word;
        n_mask = r_mask;
        n_left = r_left;
        if (b_load) begin
            n_word = b_word;
            n_mask = b_mask;
            n_left = b_left;
        end else if (w_emit) begin
            n_word = {r_word[17:0], 6'b000000};
            n_mask = {r_mask[2:0], 1'b0};
            n_left = r_left - 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held  <= 16'h0000;
            r_phase <= b64enc_pkg::PH_EMPTY;
            r_left  <= b64enc_pkg::BURST_NONE;
        end else begin
            r_held  <= n_held;
            r_phase <= n_phase;
            r_left  <= n_left;
        end
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
        r_mask <= n_mask;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_emit) begin
            r_ovalid <= 1'b1;
        end else if (o_out.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_ochar <= r_mask[3] ? r_pad
                     : b64enc_pkg::sextet_char(r_word[23:18], r_c62, r_c63);
            r_olast <= (r_left == b64enc_pkg::BURST_ONE);
        end
    end

endmodule
`default_nettype wire

FILE: design/b64enc_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// b64enc_checker
// Port-level checks of the base64 stream encoder, bound to the top level.
// ----------------------------------------------------------------------------
module b64enc_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_in_valid,
    input wire logic       i_in_ready,
    input wire logic       i_out_valid,
    input wire logic       i_out_ready,
    input wire logic [7:0] i_out_char,
    input wire logic       i_out_last
);

    // a stalled character holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_char)
            && $stable(i_out_last))
        else $error("stalled result changed");

    a_rst_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // a new run of characters follows a request through the burst and output registers
    a_rise_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(i_in_valid && i_in_ready, 2))
        else $error("result appeared without a request");

    // output register empty and no request just taken: nothing pending
    a_idle_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid && !$past(i_in_valid && i_in_ready) |-> i_in_ready)
        else $error("input blocked while output idle");

endmodule

bind base64_stream_encoder b64enc_checker u_b64enc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_char  (o_out.out_char),
    .i_out_last  (o_out.last_of_run)
);
`default_nettype wire

FILE: tb/base64_stream_encoder_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// base64_stream_encoder_test
// Self-checking bench for the streaming base64 encoder. Requests go in as
// data bytes and end-of-stream flushes, and every character that comes out
// is compared with a predicted one. The bench moves through several alphabet
// and padding settings, and both sides idle and stall at random.
// ----------------------------------------------------------------------------
module base64_stream_encoder_test;

    localparam int         CYCLE_LIMIT = 500_000;
    localparam int         TAIL_CYCLES = 8;
    localparam logic [1:0] CFG_SPARE   = 2'd3;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } t_enc_char;

    // predicted encoder state plus the characters still owed by the encoder
    class encoded_chars;
        logic [7:0]         c62;
        logic [7:0]         c63;
        logic [7:0]         pad;
        logic [15:0]        held;
        b64enc_pkg::t_phase phase;
        t_enc_char          due[$];
        logic [7:0]         run_chars[$];
        int                 bad_count = 0;
        string              letters =
            "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789";

        function void clear();
            c62   = b64enc_pkg::CHAR_62_RST;
            c63   = b64enc_pkg::CHAR_63_RST;
            pad   = b64enc_pkg::PAD_CHAR_RST;
            held  = '0;
            phase = b64enc_pkg::PH_EMPTY;
            due.delete();
            run_chars.delete();
        endfunction

        function void set_reg(logic [1:0] idx, logic [7:0] val);
            case (idx)
                b64enc_pkg::CFG_CHAR_62:  c62 = val;
                b64enc_pkg::CFG_CHAR_63:  c63 = val;
                b64enc_pkg::CFG_PAD_CHAR: pad = val;
                default: ;
            endcase
        endfunction

        function logic [7:0] lookup(logic [5:0] v);
            if (v < b64enc_pkg::SEXT_62) begin
                return letters[v];
            end else if (v == b64enc_pkg::SEXT_62) begin
                return c62;
            end
            return c63;
        endfunction

        function void add_char(logic [7:0] ch);
            run_chars = {run_chars, ch};
        endfunction

        function void take_request(logic kind, logic [7:0] b);
            logic [23:0] word;
            t_enc_char   item;
            run_chars.delete();
            word = {held, b};
            if (kind == b64enc_pkg::REQ_DATA) begin
                case (phase)
                    b64enc_pkg::PH_ONE: begin
                        held[7:0] = b;
                        phase     = b64enc_pkg::PH_TWO;
                    end
                    b64enc_pkg::PH_TWO: begin
                        add_char(lookup(word[23:18]));
                        add_char(lookup(word[17:12]));
                        add_char(lookup(word[11:6]));
                        add_char(lookup(word[5:0]));
                        held  = '0;
                        phase = b64enc_pkg::PH_EMPTY;
                    end
                    default: begin
                        held  = {b, 8'h00};
                        phase = b64enc_pkg::PH_ONE;
                    end
                endcase
            end else begin
                // flush: the missing bytes count as zero
                word = {held, 8'h00};
                if (phase == b64enc_pkg::PH_ONE) begin
                    add_char(lookup(word[23:18]));
                    add_char(lookup(word[17:12]));
                    if (pad != 8'h00) begin
                        add_char(pad);
                        add_char(pad);
                    end
                end else if (phase == b64enc_pkg::PH_TWO) begin
                    add_char(lookup(word[23:18]));
                    add_char(lookup(word[17:12]));
                    add_char(lookup(word[11:6]));
                    if (pad != 8'h00) begin
                        add_char(pad);
                    end
                end
                held  = '0;
                phase = b64enc_pkg::PH_EMPTY;
            end
            for (int i = 0; i < run_chars.size(); i++) begin
                item.ch   = run_chars[i];
                item.last = (i == run_chars.size() - 1);
                due = {due, item};
            end
        endfunction

        function void match_char(logic [7:0] ch, logic last);
            t_enc_char want;
            if (due.size() == 0) begin
                $error("out_char: expected nothing, got %0h", ch);
                bad_count++;
                return;
            end
            want = due.pop_front();
            if (ch !== want.ch) begin
                $error("out_char: expected %0h, got %0h", want.ch, ch);
                bad_count++;
            end
            if (last !== want.last) begin
                $error("last_of_run: expected %0b, got %0b", want.last, last);
                bad_count++;
            end
        endfunction
    endclass

    logic       i_clk;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic [1:0] i_cfg_idx;
    logic [7:0] i_cfg_data;
    logic       rx_ready = 1'b0;

    b64enc_in_if  in_ch();
    b64enc_out_if out_ch();

    encoded_chars chars;
    int           gap_pct     = 30;
    int           stall_pct   = 25;
    int           stall_left  = 0;
    int           cycle_count = 0;

    assign out_ch.ready = rx_ready;

    base64_stream_encoder DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // mostly short idle stretches, now and then a long one
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) begin
            return $urandom_range(1, 3);
        end else if (r < 95) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 40);
    endfunction

    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left = stall_left - 1;
            rx_ready <= 1'b0;
        end else if ($urandom_range(0, 99) < stall_pct) begin
            stall_left = idle_len() - 1;
            rx_ready <= 1'b0;
        end else begin
            rx_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
            chars.match_char(out_ch.out_char, out_ch.last_of_run);
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic send_request(input logic kind, input logic [7:0] b);
        in_ch.valid     <= 1'b1;
        in_ch.req_type  <= kind;
        in_ch.data_byte <= b;
        @(posedge i_clk);
        while (in_ch.ready !== 1'b1) @(posedge i_clk);
        chars.take_request(kind, b);
        if ($urandom_range(0, 99) < gap_pct) begin
            in_ch.valid <= 1'b0;
            repeat (idle_len()) @(posedge i_clk);
        end
    endtask

    // hold off the sender until every predicted character has come out
    task automatic drain_chars();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (chars.due.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
    endtask

    task automatic program_regs(input logic [7:0] c62, input logic [7:0] c63,
                                input logic [7:0] pad, input bit poke_spare);
        logic [7:0] spare;
        spare = 8'($urandom_range(0, 255));
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= b64enc_pkg::CFG_CHAR_62;
        i_cfg_data <= c62;
        chars.set_reg(b64enc_pkg::CFG_CHAR_62, c62);
        @(posedge i_clk);
        i_cfg_idx  <= b64enc_pkg::CFG_CHAR_63;
        i_cfg_data <= c63;
        chars.set_reg(b64enc_pkg::CFG_CHAR_63, c63);
        @(posedge i_clk);
        i_cfg_idx  <= b64enc_pkg::CFG_PAD_CHAR;
        i_cfg_data <= pad;
        chars.set_reg(b64enc_pkg::CFG_PAD_CHAR, pad);
        if (poke_spare) begin
            // unused index, must leave the alphabet alone
            @(posedge i_clk);
            i_cfg_idx  <= CFG_SPARE;
            i_cfg_data <= spare;
            chars.set_reg(CFG_SPARE, spare);
        end
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // mostly complete streams of random bytes ended by a flush, some noise
    task automatic run_stream(input int target);
        int sent;
        int len;
        sent = 0;
        while (sent < target) begin
            if ($urandom_range(0, 29) == 0) begin
                drain_chars();
            end
            if ($urandom_range(0, 9) == 0) begin
                send_request(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
                sent++;
            end else begin
                len = $urandom_range(0, 8);
                repeat (len) send_request(b64enc_pkg::REQ_DATA, 8'($urandom_range(0, 255)));
                send_request(b64enc_pkg::REQ_FLUSH, 8'($urandom_range(0, 255)));
                sent += len + 1;
            end
        end
        send_request(b64enc_pkg::REQ_FLUSH, 8'($urandom_range(0, 255)));
        drain_chars();
    endtask

    initial begin
        logic [7:0] group_bytes[12];
        group_bytes = '{8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF,
                        8'hFB, 8'hEF, 8'hBE, 8'hD3, 8'h4D, 8'h34};
        chars = new();
        chars.clear();
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_idx       = b64enc_pkg::CFG_CHAR_62;
        i_cfg_data      = 8'h00;
        in_ch.valid     = 1'b0;
        in_ch.req_type  = b64enc_pkg::REQ_DATA;
        in_ch.data_byte = 8'h00;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // default alphabet: zeros, ones, value 62 everywhere, digits
        foreach (group_bytes[i]) send_request(b64enc_pkg::REQ_DATA, group_bytes[i]);
        send_request(b64enc_pkg::REQ_DATA, 8'h4D);
        send_request(b64enc_pkg::REQ_FLUSH, 8'hFF);
        send_request(b64enc_pkg::REQ_DATA, 8'h4D);
        send_request(b64enc_pkg::REQ_DATA, 8'h61);
        send_request(b64enc_pkg::REQ_FLUSH, 8'h00);
        // flush with nothing held
        send_request(b64enc_pkg::REQ_FLUSH, 8'h5A);
        drain_chars();

        // padding off, extreme alphabet characters
        program_regs(8'h00, 8'hFF, 8'h00, 1'b1);
        send_request(b64enc_pkg::REQ_DATA, 8'hFB);
        send_request(b64enc_pkg::REQ_FLUSH, 8'h00);
        send_request(b64enc_pkg::REQ_DATA, 8'hFF);
        send_request(b64enc_pkg::REQ_DATA, 8'hFF);
        send_request(b64enc_pkg::REQ_FLUSH, 8'hFF);
        drain_chars();

        program_regs(8'($urandom), 8'($urandom), 8'($urandom_range(1, 255)), 1'b0);
        run_stream(60);

        program_regs(8'hFF, 8'h00, 8'hFF, 1'b1);
        gap_pct   = 50;
        stall_pct = 40;
        run_stream(60);

        // no idling on either side
        program_regs(8'h2D, 8'h5F, 8'h00, 1'b0);
        gap_pct   = 0;
        stall_pct = 0;
        run_stream(60);

        program_regs(8'h00, 8'h00, 8'h01, 1'b0);
        gap_pct   = 10;
        stall_pct = 60;
        run_stream(60);

        program_regs(8'($urandom), 8'($urandom), 8'($urandom), 1'b1);
        gap_pct   = 60;
        stall_pct = 10;
        run_stream(60);

        program_regs(b64enc_pkg::CHAR_62_RST, b64enc_pkg::CHAR_63_RST,
                     b64enc_pkg::PAD_CHAR_RST, 1'b0);
        gap_pct   = 30;
        stall_pct = 25;
        run_stream(15);

        if (chars.bad_count == 0 && chars.due.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule

FILE: base64_stream_encoder.f
design/b64enc_pkg.sv
design/b64enc_in_if.sv
design/b64enc_out_if.sv
design/base64_stream_encoder.sv
design/b64enc_checker.sv
tb/base64_stream_encoder_test.sv
